// File: rtl/core/sbpf_pkg.sv
// ----------------------------------------------------------------------------
// sbpf_pkg: servo bus packet framer package
// Shared constants, the framing command record and slot numbering.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sbpf_pkg;

  // Default upper limit on the declared parameter count
  localparam int unsigned MaxParamsDefault = 26;

  // Sync byte and length offset of an instruction packet
  localparam logic [7:0] SyncByte = 8'hFF;
  localparam logic [7:0] LenExtra = 8'd2;

  // Depth of the command queue between front and back
  localparam int unsigned CmdQueueDepth = 2;

  // Byte slots of one command, in emission order
  localparam int unsigned NumSlots  = 7;
  localparam int unsigned SlotSync0 = 0;
  localparam int unsigned SlotSync1 = 1;
  localparam int unsigned SlotId    = 2;
  localparam int unsigned SlotLen   = 3;
  localparam int unsigned SlotInstr = 4;
  localparam int unsigned SlotParam = 5;
  localparam int unsigned SlotCks   = 6;

  // One classified input item, ready for emission
  typedef struct packed {
    logic       hdr;        // first item of a packet: emit header
    logic [7:0] dest_id;
    logic [7:0] len;
    logic [7:0] instr;
    logic       has_param;  // emit parameter byte
    logic [7:0] param;
    logic       last;       // emit checksum
    logic [7:0] cks;
  } sbpf_cmd_t;

endpackage

`default_nettype wire

// File: rtl/core/sbpf_if.sv
// ----------------------------------------------------------------------------
// sbpf_if: framer channel interfaces
// Valid/ready channels for input items and framed output bytes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface sbpf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] dest_id;
  logic [7:0] instruction;
  logic [4:0] param_cnt;
  logic [7:0] param_byte;
  logic       last_item;

  modport source (
    output valid, dest_id, instruction, param_cnt, param_byte, last_item,
    input  ready
  );
  modport sink (
    input  valid, dest_id, instruction, param_cnt, param_byte, last_item,
    output ready
  );
endinterface

interface sbpf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       end_of_packet;

  modport source (output valid, out_byte, end_of_packet, input ready);
  modport sink   (input valid, out_byte, end_of_packet, output ready);
endinterface

`default_nettype wire

// File: rtl/core/servo_bus_packet_framer.sv
// ----------------------------------------------------------------------------
// servo_bus_packet_framer: servo bus instruction packet framer
// Frames instruction packets (sync, id, length, instruction, parameters,
// checksum) from a stream of items, one output byte per transfer.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                          | flow
//  in_i    | in  | dest_id, instruction, param_cnt, param_byte,     | valid/ready
//          |     | last_item                                        |
//  out_o   | out | out_byte, end_of_packet                          | valid/ready
//
//  The emitter sends one byte per cycle while out_o is not stalled. An item
//  yields up to 7 bytes (a header item at least 5, others maybe none), so the
//  unstalled non-last parameter items after a header go one item per cycle.
//  A two-entry command queue sits between classifier and emitter; input
//  stalls only when it is full. Output is registered and advances on each
//  transfer. Reset is asynchronous, active low, and closes any open packet.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module servo_bus_packet_framer #(
  parameter int unsigned MAX_PARAMS = sbpf_pkg::MaxParamsDefault
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  sbpf_in_if.sink     in_i,
  sbpf_out_if.source  out_o
);

  sbpf_pkg::sbpf_cmd_t push_cmd;
  sbpf_pkg::sbpf_cmd_t head_cmd;
  logic push, pop, q_empty, q_full;

  sbpf_front #(
    .MAX_PARAMS(MAX_PARAMS)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .q_full_i(q_full),
    .push_o  (push),
    .cmd_o   (push_cmd)
  );

  sbpf_cmd_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (push_cmd),
    .pop_i  (pop),
    .head_o (head_cmd),
    .empty_o(q_empty),
    .full_o (q_full)
  );

  sbpf_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head_cmd),
    .empty_i(q_empty),
    .pop_o  (pop),
    .out_o  (out_o)
  );

endmodule

`default_nettype wire

// File: rtl/core/sbpf_front.sv
// ----------------------------------------------------------------------------
// sbpf_front: item classifier
// Accepts input items, tracks packet state and the running checksum, and
// turns each item into one framing command.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sbpf_front #(
  parameter int unsigned MAX_PARAMS = sbpf_pkg::MaxParamsDefault
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  sbpf_in_if.sink          in_i,
  input  wire              q_full_i,
  output logic             push_o,
  output sbpf_pkg::sbpf_cmd_t cmd_o
);

  localparam logic [7:0] MaxCount = MAX_PARAMS[7:0];

  logic       in_packet_q, in_packet_d;
  logic [7:0] sum_q, sum_d;
  logic       has_params_q, has_params_d;

  logic       first;
  logic [7:0] sat_count;
  logic [7:0] len;
  logic [7:0] base;
  logic       hp;
  logic [7:0] sum_new;

  assign in_i.ready = !q_full_i;
  assign push_o     = in_i.valid && in_i.ready;

  // Classify the item and update the checksum sum
  always_comb begin
    first     = !in_packet_q;
    sat_count = ({3'b000, in_i.param_cnt} > MaxCount) ? MaxCount
                                                      : {3'b000, in_i.param_cnt};
    len       = sat_count + sbpf_pkg::LenExtra;
    base      = first ? (in_i.dest_id + len + in_i.instruction) : sum_q;
    hp        = first ? (sat_count != 8'd0) : has_params_q;
    sum_new   = base + (hp ? in_i.param_byte : 8'd0);

    cmd_o.hdr       = first;
    cmd_o.dest_id   = in_i.dest_id;
    cmd_o.len       = len;
    cmd_o.instr     = in_i.instruction;
    cmd_o.has_param = hp;
    cmd_o.param     = in_i.param_byte;
    cmd_o.last      = in_i.last_item;
    cmd_o.cks       = ~sum_new;

    in_packet_d  = in_packet_q;
    sum_d        = sum_q;
    has_params_d = has_params_q;
    if (push_o) begin
      if (in_i.last_item) begin
        in_packet_d  = 1'b0;
        sum_d        = 8'd0;
        has_params_d = 1'b0;
      end else begin
        in_packet_d  = 1'b1;
        sum_d        = sum_new;
        has_params_d = hp;
      end
    end
  end

  // Packet state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_packet_q  <= 1'b0;
      sum_q        <= 8'd0;
      has_params_q <= 1'b0;
    end else begin
      in_packet_q  <= in_packet_d;
      sum_q        <= sum_d;
      has_params_q <= has_params_d;
    end
  end

  // Outside a packet the sum and parameter flag are clear
  a_idle_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_packet_q |-> (sum_q == 8'd0 && !has_params_q))
    else $error("framer state not clear between packets");

  // A last item closes the packet
  a_last_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && in_i.last_item) |=> !in_packet_q)
    else $error("packet still open after last item");

endmodule

`default_nettype wire

// File: rtl/core/sbpf_cmd_fifo.sv
// ----------------------------------------------------------------------------
// sbpf_cmd_fifo: command queue
// Short FIFO of framing commands between the classifier and the emitter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sbpf_cmd_fifo (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 push_i,
  input  sbpf_pkg::sbpf_cmd_t cmd_i,
  input  wire                 pop_i,
  output sbpf_pkg::sbpf_cmd_t head_o,
  output logic                empty_o,
  output logic                full_o
);

  localparam int unsigned Depth  = sbpf_pkg::CmdQueueDepth;
  localparam int unsigned PtrW   = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CountW = $clog2(Depth + 1);

  sbpf_pkg::sbpf_cmd_t mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CountW-1:0] count_q;

  assign empty_o = (count_q == CountW'(0));
  assign full_o  = (count_q == CountW'(Depth));
  assign head_o  = mem_q[rd_ptr_q];

  // Storage, written at the tail
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("command queue overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("command queue underflow");

endmodule

`default_nettype wire

// File: rtl/core/sbpf_back.sv
// ----------------------------------------------------------------------------
// sbpf_back: byte emitter
// Walks the enabled byte slots of the head command, one byte per cycle
// while the output is not stalled, into a registered output stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sbpf_back (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  sbpf_pkg::sbpf_cmd_t head_i,
  input  wire                 empty_i,
  output logic                pop_o,
  sbpf_out_if.source          out_o
);

  localparam int unsigned N = sbpf_pkg::NumSlots;

  logic [N-1:0] rem_q, rem_d;
  logic         out_valid_q, out_valid_d;
  logic [7:0]   out_byte_q, out_byte_d;
  logic         eop_q, eop_d;

  logic [N-1:0] slot_en;
  logic [N-1:0] eff;
  logic [N-1:0] pick;
  logic [N-1:0] rest;
  logic [7:0]   slot_byte [N];
  logic [7:0]   sel_byte;
  logic         load_ok;

  // Slot bytes and enables of the head command
  always_comb begin
    slot_byte[sbpf_pkg::SlotSync0] = sbpf_pkg::SyncByte;
    slot_byte[sbpf_pkg::SlotSync1] = sbpf_pkg::SyncByte;
    slot_byte[sbpf_pkg::SlotId]    = head_i.dest_id;
    slot_byte[sbpf_pkg::SlotLen]   = head_i.len;
    slot_byte[sbpf_pkg::SlotInstr] = head_i.instr;
    slot_byte[sbpf_pkg::SlotParam] = head_i.param;
    slot_byte[sbpf_pkg::SlotCks]   = head_i.cks;

    slot_en = '0;
    slot_en[sbpf_pkg::SlotSync0] = head_i.hdr;
    slot_en[sbpf_pkg::SlotSync1] = head_i.hdr;
    slot_en[sbpf_pkg::SlotId]    = head_i.hdr;
    slot_en[sbpf_pkg::SlotLen]   = head_i.hdr;
    slot_en[sbpf_pkg::SlotInstr] = head_i.hdr;
    slot_en[sbpf_pkg::SlotParam] = head_i.has_param;
    slot_en[sbpf_pkg::SlotCks]   = head_i.last;
  end

  // Pick the lowest pending slot and step through the command
  always_comb begin
    eff      = empty_i ? '0 : (slot_en & rem_q);
    pick     = eff & (~eff + 1'b1);
    rest     = eff & ~pick;
    load_ok  = !out_valid_q || out_o.ready;

    sel_byte = 8'd0;
    for (int i = 0; i < N; i++) begin
      sel_byte = sel_byte | (pick[i] ? slot_byte[i] : 8'd0);
    end

    rem_d       = rem_q;
    pop_o       = 1'b0;
    out_valid_d = out_valid_q && !out_o.ready;
    out_byte_d  = out_byte_q;
    eop_d       = eop_q;

    if (!empty_i && eff == '0) begin
      // command with nothing to send
      pop_o = 1'b1;
      rem_d = '1;
    end else if (eff != '0 && load_ok) begin
      out_valid_d = 1'b1;
      out_byte_d  = sel_byte;
      eop_d       = pick[sbpf_pkg::SlotCks];
      if (rest == '0) begin
        pop_o = 1'b1;
        rem_d = '1;
      end else begin
        rem_d = rest;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q       <= '1;
      out_valid_q <= 1'b0;
    end else begin
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    eop_q      <= eop_d;
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.out_byte      = out_byte_q;
  assign out_o.end_of_packet = eop_q;

  a_rem_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_q != '0)
    else $error("slot walk lost its position");

endmodule

`default_nettype wire
